// ===== hdl/lpcre_pkg.sv =====
// Shared types, register codes and prediction arithmetic for the LPC residual encoder.
// No dependencies; imported by the cell and the top level.
package lpcre_pkg;

	localparam int DATA_W     = 32;
	localparam int SUM_W      = 64;
	localparam int ORDER_W    = 6;
	localparam int SHIFT_W    = 5;
	localparam int COEF_IDX_W = 5;
	localparam int REG_IDX_W  = 2;
	localparam int S_TDATA_W  = 72;
	localparam int S_TUSER_W  = 2;

	localparam logic [REG_IDX_W-1:0] REG_ORDER = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SHIFT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_WIDE  = 2'd2;

	localparam logic MODE_COEF   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAIT,
		ST_FINISH
	} lpcre_state_t;

	// Per-cell control group
	typedef struct packed {
		logic shift_en;
		logic coef_we;
	} lpcre_cell_ctrl_t;

	// Shift the tap sum and bring it to 32 bits: saturate in wide mode,
	// wrap the sum at 32 bits in narrow mode.
	function automatic logic [DATA_W-1:0] lpcre_predict(
		input logic [SUM_W-1:0]   acc,
		input logic [SHIFT_W-1:0] sh,
		input logic               wide
	);
		logic signed [SUM_W-1:0]  p;
		logic signed [DATA_W-1:0] n;
		logic [DATA_W-1:0]        r;
		p = $signed(acc) >>> sh;
		n = $signed(acc[DATA_W-1:0]) >>> sh;
		if (!wide) begin
			r = n;
		end else if (p > 64'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (p < -64'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = p[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== hdl/lpcre_cell.sv =====
// One tap cell: a history slot, a coefficient slot, a registered product and a
// registered running sum handed to the next cell. Depends on lpcre_pkg.
module lpcre_cell
	import lpcre_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  lpcre_cell_ctrl_t         ctrl,
	input  logic signed [DATA_W-1:0] hist_in,
	input  logic signed [DATA_W-1:0] coef_wdata,
	input  logic [SUM_W-1:0]         sum_in,
	output logic signed [DATA_W-1:0] hist_out,
	output logic [SUM_W-1:0]         sum_out
);

	logic signed [DATA_W-1:0] hist_q;
	logic signed [DATA_W-1:0] coef_q;
	logic signed [SUM_W-1:0]  prod_s1;
	logic [SUM_W-1:0]         sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (ctrl.shift_en) begin
			hist_q <= hist_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.coef_we) begin
			coef_q <= coef_wdata;
		end
		prod_s1 <= coef_q * hist_q;
		// add own product to the partial sum from the upstream cell
		sum_q   <= sum_in + SUM_W'(prod_s1);
	end

	assign hist_out = hist_q;
	assign sum_out  = sum_q;

endmodule

// ===== hdl/lpc_residual_encoder_core.sv =====
// Top level of the LPC residual encoder: stream ports, APB registers, control and
// the row of tap cells. Depends on lpcre_pkg and lpcre_cell.
//
//   channel  dir  payload                                              handshake
//   s_*      in   tdata: coef_index, coef_value, sample; tuser: mode,   tvalid/tready
//                 block_start
//   m_*      out  tdata: residual                                      tvalid/tready
//   apb      in   order @0x0, shift @0x4, wide_mode @0x8               psel/penable
//
// A coefficient beat writes the cell its index names; the control stays in idle.
// A warm-up sample goes to the finish state with a zero prediction; a predicted
// sample waits while the sum walks down the cell row one cell per cycle (taps =
// order, capped at MAX_ORDER). Finish loads the output and returns to idle.
// Reset clears the history, the warm-up count, shift and the output valid; order and wide_mode reset to one.
// A full, stalled output register holds the next result in the finish state.
module lpc_residual_encoder_core
	import lpcre_pkg::*;
#(
	parameter int MAX_ORDER = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// coef_index, coef_value, sample from bit 0 up, zero padded to 72 bits
	input  logic [S_TDATA_W-1:0] s_tdata,
	// mode, block_start from bit 0 up
	input  logic [S_TUSER_W-1:0] s_tuser,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// residual
	output logic [DATA_W-1:0]    m_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;

	// unpack the input beat
	logic                  in_mode;
	logic                  in_block_start;
	logic [COEF_IDX_W-1:0] in_coef_index;
	logic [DATA_W-1:0]     in_coef_value;
	logic [DATA_W-1:0]     in_sample;

	assign in_mode        = s_tuser[0];
	assign in_block_start = s_tuser[1];
	assign in_coef_index  = s_tdata[4:0];
	assign in_coef_value  = s_tdata[36:5];
	assign in_sample      = s_tdata[68:37];

	// configuration registers
	logic [ORDER_W-1:0] order_q;
	logic [SHIFT_W-1:0] shift_q;
	logic               wide_q;
	logic               cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= ORDER_W'(1);
			shift_q <= '0;
			wide_q  <= 1'b1;
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_ORDER: order_q <= pwdata[ORDER_W-1:0];
				REG_SHIFT: shift_q <= pwdata[SHIFT_W-1:0];
				REG_WIDE:  wide_q  <= pwdata[0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ORDER: prdata = 32'(order_q);
			REG_SHIFT: prdata = 32'(shift_q);
			REG_WIDE:  prdata = 32'(wide_q);
			default:   prdata = '0;
		endcase
	end

	// cap the order at the number of cells
	logic [ORDER_W-1:0] taps;
	assign taps = (order_q > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order_q;

	// control state
	lpcre_state_t       state_q;
	lpcre_state_t       state_d;
	logic [ORDER_W-1:0] cnt_q;
	logic [ORDER_W-1:0] wc_q;
	logic [DATA_W-1:0]  sample_q;
	logic [DATA_W-1:0]  pred_q;
	logic [DATA_W-1:0]  m_tdata_q;
	logic               m_tvalid_q;

	logic               in_beat;
	logic               sample_beat;
	logic               coef_beat;
	logic [ORDER_W-1:0] wc_base;
	logic               warm;
	logic               out_load;

	logic [SUM_W-1:0]   sum_row [MAX_ORDER];
	logic [DATA_W-1:0]  hist_row [MAX_ORDER];
	logic [SUM_W-1:0]   sum_sel;

	assign in_beat     = s_tvalid && s_tready;
	assign sample_beat = in_beat && (in_mode == MODE_SAMPLE);
	assign coef_beat   = in_beat && (in_mode == MODE_COEF);
	// block start restarts warm-up before this sample is judged
	assign wc_base     = in_block_start ? '0 : wc_q;
	assign warm        = wc_base < taps;

	// pick the sum at the last active tap; an empty sum predicts zero
	assign sum_sel = (taps == '0) ? '0 : sum_row[IDX_W'(taps - ORDER_W'(1))];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sample_beat) begin
					state_d = warm ? ST_FINISH : ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (cnt_q == '0) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the controller
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		out_load = (state_q == ST_FINISH) && (!m_tvalid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			wc_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sample_beat) begin
				// hold the sum row steady for one product stage and taps adds
				cnt_q <= taps;
				wc_q  <= warm ? wc_base + ORDER_W'(1) : wc_base;
			end else if (state_q == ST_WAIT && cnt_q != '0) begin
				cnt_q <= cnt_q - ORDER_W'(1);
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_beat) begin
			sample_q <= in_sample;
			// warm-up passes the sample through
			pred_q   <= '0;
		end else if (state_q == ST_WAIT && cnt_q == '0) begin
			pred_q <= lpcre_predict(sum_sel, shift_q, wide_q);
		end
		if (out_load) begin
			m_tdata_q <= sample_q - pred_q;
		end
	end

	assign m_tdata  = m_tdata_q;
	assign m_tvalid = m_tvalid_q;

	// row of tap cells; the history advances as the result leaves
	for (genvar j = 0; j < MAX_ORDER; j++) begin : g_cell
		lpcre_cell_ctrl_t  ctrl;
		logic [DATA_W-1:0] hist_in;
		logic [SUM_W-1:0]  sum_in;

		assign ctrl.shift_en = out_load;
		assign ctrl.coef_we  = coef_beat && (in_coef_index == COEF_IDX_W'(j));

		if (j == 0) begin : g_head
			assign hist_in = sample_q;
			assign sum_in  = '0;
		end else begin : g_body
			assign hist_in = hist_row[j-1];
			assign sum_in  = sum_row[j-1];
		end

		lpcre_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.hist_in    (hist_in),
			.coef_wdata (in_coef_value),
			.sum_in     (sum_in),
			.hist_out   (hist_row[j]),
			.sum_out    (sum_row[j])
		);
	end

`ifndef SYNTHESIS
	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (m_tvalid && state_q == ST_IDLE))
		else $error("result not presented after finish");

	a_wait_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT) |-> (cnt_q <= ORDER_W'(MAX_ORDER)))
		else $error("tap wait count out of range");

	a_warmup_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sample_beat |=> (wc_q <= ORDER_W'(MAX_ORDER) && state_q != ST_IDLE))
		else $error("warm-up count or state wrong after sample");
`endif

endmodule
